@@ hdl/bbs_bit_generator_macros.svh @@
// ----------------------------------------------------------------------------
// bbs_bit_generator_macros.svh
// Assertion helpers for the BBS generator checker.
// ----------------------------------------------------------------------------
`ifndef BBS_BIT_GENERATOR_MACROS_SVH
`define BBS_BIT_GENERATOR_MACROS_SVH

// same-cycle implication, held off during reset
`define BBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbs_bit_generator: check failed");

// next-cycle implication, held off during reset
`define BBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbs_bit_generator: check failed");

// next-cycle implication that also covers reset itself
`define BBS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bbs_bit_generator: check failed");

`endif

@@ hdl/bbs_pkg.sv @@
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the BBS bit generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbs_pkg;

  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 5;
  localparam int BITS_PER_BYTE = 8;

  localparam logic [7:0] ASCII_ZERO = 8'd48;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_SEED    = 2'd1;
  localparam logic [1:0] REG_PACKED  = 2'd2;

  typedef enum logic {
    OP_SQUARE = 1'b0,
    OP_GCD    = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic is_one;
  } unit_rsp_t;

endpackage

@@ hdl/bbs_modunit.sv @@
// ----------------------------------------------------------------------------
// bbs_modunit
// Iterative modular unit: v*v mod m by shift-and-add (with a restoring
// pre-reduction of v when v >= m), and a binary gcd. One bit or one
// subtract step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbs_modunit #(
  parameter int W = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbs_pkg::unit_req_t req,
  input  logic [W-1:0]      opa,
  input  logic [W-1:0]      opm,
  output bbs_pkg::unit_rsp_t rsp,
  output logic [W-1:0]      result
);

  localparam int CW = $clog2(W);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_RED  = 4'b0010,
    U_MUL  = 4'b0100,
    U_GCD  = 4'b1000
  } ustate_t;

  ustate_t         ustate_r, ustate_nxt;
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    bits_r, bits_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;

  logic [W:0]      rem_sh;
  logic [W-1:0]    rem_new;
  logic [W:0]      sum;
  logic [W-1:0]    sum_red;
  logic [W:0]      dbl;
  logic [W-1:0]    dbl_red;
  logic            a_gt_b;
  logic [W-1:0]    diff;

  always_comb begin
    rem_sh  = {acc_r, bits_r[W-1]};
    rem_new = (rem_sh >= {1'b0, b_r}) ? W'(rem_sh - {1'b0, b_r}) : rem_sh[W-1:0];
    sum     = {1'b0, acc_r} + {1'b0, a_r};
    sum_red = (sum >= {1'b0, b_r}) ? W'(sum - {1'b0, b_r}) : sum[W-1:0];
    dbl     = {a_r, 1'b0};
    dbl_red = (dbl >= {1'b0, b_r}) ? W'(dbl - {1'b0, b_r}) : dbl[W-1:0];
    a_gt_b  = (a_r > b_r);
    diff    = a_gt_b ? (a_r - b_r) : (b_r - a_r);
  end

  always_comb begin
    ustate_nxt = ustate_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    bits_nxt   = bits_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    case (ustate_r)
      U_IDLE: begin
        if (req.start) begin
          b_nxt = opm;
          if (req.op == bbs_pkg::OP_GCD) begin
            a_nxt      = opa;
            ustate_nxt = U_GCD;
          end else if (opa >= opm) begin
            acc_nxt    = '0;
            bits_nxt   = opa;
            cnt_nxt    = CW'(W - 1);
            ustate_nxt = U_RED;
          end else begin
            a_nxt      = opa;
            bits_nxt   = opa;
            acc_nxt    = '0;
            ustate_nxt = U_MUL;
          end
        end
      end
      U_RED: begin
        acc_nxt  = rem_new;
        bits_nxt = {bits_r[W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          a_nxt      = rem_new;
          bits_nxt   = rem_new;
          acc_nxt    = '0;
          ustate_nxt = U_MUL;
        end
      end
      U_MUL: begin
        if (bits_r == '0) begin
          done_nxt   = 1'b1;
          ustate_nxt = U_IDLE;
        end else begin
          if (bits_r[0]) begin
            acc_nxt = sum_red;
          end
          a_nxt    = dbl_red;
          bits_nxt = {1'b0, bits_r[W-1:1]};
        end
      end
      U_GCD: begin
        // gcd is known to be odd here, so factors of two drop freely
        if (!a_r[0]) begin
          a_nxt = {1'b0, a_r[W-1:1]};
        end else if (!b_r[0]) begin
          b_nxt = {1'b0, b_r[W-1:1]};
        end else if (a_r == b_r) begin
          acc_nxt    = a_r;
          done_nxt   = 1'b1;
          ustate_nxt = U_IDLE;
        end else if (a_gt_b) begin
          a_nxt = diff;
        end else begin
          b_nxt = diff;
        end
      end
      default: begin
        ustate_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= U_IDLE;
      done_r   <= 1'b0;
    end else begin
      ustate_r <= ustate_nxt;
      done_r   <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    bits_r <= bits_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign result     = acc_r;
  assign rsp.done   = done_r;
  assign rsp.is_one = (acc_r == W'(1));

endmodule

@@ hdl/bbs_bit_generator.sv @@
// ----------------------------------------------------------------------------
// bbs_bit_generator
// Blum Blum Shub bit generator with APB-style register port.
// ----------------------------------------------------------------------------
// One request returns one byte: eight squarings packed MSB first, or one
// squaring as ASCII '0'/'1'. All arithmetic runs on a single shared
// modular unit, one shift/add step per cycle, and the input is stalled
// until the request is finished. A squaring first reduces the residue
// when it is not below the modulus, as after a modulus change. A restart
// or the first request after reset first checks the seed and, if it
// passes, runs a binary gcd of seed and modulus, in steps of one subtract
// or one halving each. A bad seed latches the error flag, and requests
// then return 0 until a good restart.
// Registers (64-bit data, 8-byte stride): 0 modulus, 1 seed, 2 packed_mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbs_bit_generator #(
  parameter int MOD_WIDTH = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_seed_error,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [bbs_pkg::DATA_W-1:0]  pwdata,
  output logic [bbs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int W = MOD_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_SQ   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [W-1:0]  modulus_r, seed_r;
  logic          packed_r;
  logic [W-1:0]  residue_r, residue_nxt;
  logic          seeded_r, seeded_nxt;
  logic          err_r, err_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [2:0]    left_r, left_nxt;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_err_r;

  bbs_pkg::unit_req_t ureq;
  bbs_pkg::unit_rsp_t ursp;
  logic [W-1:0]       uopa;
  logic [W-1:0]       uresult;

  logic          accept;
  logic          reseed;
  logic          seed_bad;
  logic          mod_small;
  logic [7:0]    shifted;
  logic          load_out;

  // ---------------- register port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(3);
      seed_r    <= W'(1);
      packed_r  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        bbs_pkg::REG_MODULUS: modulus_r <= pwdata[W-1:0];
        bbs_pkg::REG_SEED:    seed_r    <= pwdata[W-1:0];
        bbs_pkg::REG_PACKED:  packed_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      bbs_pkg::REG_MODULUS: prdata = bbs_pkg::DATA_W'(modulus_r);
      bbs_pkg::REG_SEED:    prdata = bbs_pkg::DATA_W'(seed_r);
      bbs_pkg::REG_PACKED:  prdata = bbs_pkg::DATA_W'(packed_r);
      default:              prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign reseed    = in_restart || !seeded_r;
  assign mod_small = (modulus_r < W'(2));
  // both even means gcd > 1; the gcd unit relies on this being weeded out
  assign seed_bad  = mod_small || (seed_r == '0) || (seed_r >= modulus_r) ||
                     (!seed_r[0] && !modulus_r[0]);
  assign shifted   = {byte_r[6:0], uresult[0]};
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // unit operand: fresh result while chaining, stored residue for a new request, seed for the gcd and after a good gcd
  always_comb begin
    if (state_r == S_SQ) begin
      uopa = uresult;
    end else if (state_r == S_IDLE && ureq.op == bbs_pkg::OP_SQUARE) begin
      uopa = residue_r;
    end else begin
      uopa = seed_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    residue_nxt = residue_r;
    seeded_nxt  = seeded_r;
    err_nxt     = err_r;
    byte_nxt    = byte_r;
    left_nxt    = left_r;
    ureq.start  = 1'b0;
    ureq.op     = bbs_pkg::OP_SQUARE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (reseed) begin
            seeded_nxt = 1'b1;
            if (seed_bad) begin
              err_nxt   = 1'b1;
              byte_nxt  = '0;
              state_nxt = S_DONE;
            end else begin
              ureq.start = 1'b1;
              ureq.op    = bbs_pkg::OP_GCD;
              state_nxt  = S_GCD;
            end
          end else if (err_r || mod_small) begin
            err_nxt   = 1'b1;
            byte_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            ureq.start = 1'b1;
            byte_nxt   = '0;
            left_nxt   = packed_r ? 3'(bbs_pkg::BITS_PER_BYTE - 1) : 3'd0;
            state_nxt  = S_SQ;
          end
        end
      end
      S_GCD: begin
        if (ursp.done) begin
          if (ursp.is_one) begin
            err_nxt     = 1'b0;
            residue_nxt = seed_r;
            ureq.start  = 1'b1;
            byte_nxt    = '0;
            left_nxt    = packed_r ? 3'(bbs_pkg::BITS_PER_BYTE - 1) : 3'd0;
            state_nxt   = S_SQ;
          end else begin
            err_nxt   = 1'b1;
            byte_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_SQ: begin
        if (ursp.done) begin
          residue_nxt = uresult;
          if (left_r == '0) begin
            byte_nxt  = packed_r ? shifted
                                 : bbs_pkg::ASCII_ZERO + {7'd0, uresult[0]};
            state_nxt = S_DONE;
          end else begin
            byte_nxt   = shifted;
            left_nxt   = left_r - 1'b1;
            ureq.start = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      residue_r   <= '0;
      seeded_r    <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      residue_r <= residue_nxt;
      seeded_r  <= seeded_nxt;
      err_r     <= err_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    byte_r <= byte_nxt;
    left_r <= left_nxt;
    if (load_out) begin
      out_byte_r <= byte_r;
      out_err_r  <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_seed_error = out_err_r;

  bbs_modunit #(
    .W (W)
  ) u_modunit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .opa    (uopa),
    .opm    (modulus_r),
    .rsp    (ursp),
    .result (uresult)
  );

endmodule

@@ hdl/bbs_bit_generator_chk.sv @@
// ----------------------------------------------------------------------------
// bbs_bit_generator_chk
// Port-level checks for the BBS generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bbs_bit_generator_macros.svh"

module bbs_bit_generator_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_seed_error
);

  // a held result keeps its value
  `BBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_seed_error))

  // error results carry a zero byte
  `BBS_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_seed_error, out_byte == 8'd0)

  // a taken request keeps the block busy for at least the next cycle
  `BBS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // reset empties the output register
  `BBS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind bbs_bit_generator bbs_bit_generator_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_seed_error (out_seed_error)
);

@@ tb/bbs_bit_generator_test.sv @@
// ----------------------------------------------------------------------------
// bbs_bit_generator_test
// Self-checking bench for the Blum Blum Shub bit generator.
// ----------------------------------------------------------------------------
// A directed table covers seeding after reset, bad seeds, the latched error,
// small and changed moduli, late seed writes and mode switches. Random phases
// follow, each reprogramming some registers over the register port and then
// issuing a run of requests, checked against an internal generator model.
// Sender and receiver idle and stall in rotating patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbs_bit_generator_test;

  localparam int          TOTAL_REQUESTS  = 1150;
  localparam int          WATCHDOG_LIMIT  = 20000;
  localparam int          HOLD_OFF_CYCLES = 1500;
  localparam int          END_WAIT_CYCLES = 1400;
  localparam logic [63:0] MASK63          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BIG_BLUM        = 64'd4294967291 * 64'd2147483647;

  typedef enum logic [1:0] {
    TRAFFIC_NONE, TRAFFIC_SENDER, TRAFFIC_RECEIVER, TRAFFIC_BOTH
  } traffic_t;

  typedef enum logic { ROW_WRITE, ROW_REQUEST } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic        restart;
    logic        typed;
    logic [7:0]  typed_byte;
    logic        typed_err;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       seed_err;
  } gen_result_t;

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_seed_error;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [bbs_pkg::ADDR_W-1:0] paddr     = '0;
  logic [bbs_pkg::DATA_W-1:0] pwdata    = '0;
  logic [bbs_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  bbs_bit_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_seed_error (out_seed_error),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // generator model state
  logic [63:0] gen_modulus;
  logic [63:0] gen_seed;
  logic        gen_packed;
  logic [63:0] gen_residue;
  logic        gen_seeded;
  logic        gen_error;

  gen_result_t pending_results[$];
  stim_row_t   directed_rows[$];

  traffic_t    traffic_mode = TRAFFIC_NONE;
  logic        typed_pending = 1'b0;
  gen_result_t typed_result;

  int          mismatches    = 0;
  int          quiet_cycles  = 0;
  int          results_seen  = 0;
  int          error_results = 0;
  int          requests_sent = 0;
  int          restarts_sent = 0;
  int          reg_writes    = 0;
  int          hold_off_asks = 0;
  int          hold_off_taken = 0;
  int          hold_left     = 0;

  int unsigned prime_3mod4[16] = '{3, 7, 11, 19, 23, 31, 43, 47,
                                   59, 67, 71, 79, 83, 103, 107, 127};

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // shift-and-add v*v mod m, operands below 2^63
  function automatic logic [63:0] mod_square(logic [63:0] v, logic [63:0] m);
    logic [63:0] addend;
    logic [63:0] bits;
    logic [63:0] acc;
    addend = v % m;
    bits   = addend;
    acc    = 64'd0;
    while (bits != 0) begin
      if (bits[0]) begin
        acc = acc + addend;
        if (acc >= m) acc = acc - m;
      end
      addend = addend << 1;
      if (addend >= m) addend = addend - m;
      bits = bits >> 1;
    end
    return acc;
  endfunction

  function automatic gen_result_t next_output(logic restart);
    gen_result_t r;
    logic [7:0]  acc_byte;
    r        = '0;
    acc_byte = 8'd0;
    if (restart || !gen_seeded) begin
      gen_seeded = 1'b1;
      if (gen_modulus < 2 || gen_seed == 0 || gen_seed >= gen_modulus ||
          gcd64(gen_modulus, gen_seed) != 1) begin
        gen_error = 1'b1;
      end else begin
        gen_error   = 1'b0;
        gen_residue = gen_seed;
      end
    end
    if (!gen_error && gen_modulus < 2) gen_error = 1'b1;
    if (gen_error) begin
      r.seed_err = 1'b1;
      return r;
    end
    if (gen_packed) begin
      for (int i = 0; i < bbs_pkg::BITS_PER_BYTE; i++) begin
        gen_residue = mod_square(gen_residue, gen_modulus);
        acc_byte    = {acc_byte[6:0], gen_residue[0]};
      end
      r.data = acc_byte;
    end else begin
      gen_residue = mod_square(gen_residue, gen_modulus);
      r.data      = bbs_pkg::ASCII_ZERO + {7'd0, gen_residue[0]};
    end
    return r;
  endfunction

  function automatic logic [63:0] rand63();
    return {$urandom, $urandom} & MASK63;
  endfunction

  function automatic bit sender_rests();
    case (traffic_mode)
      TRAFFIC_SENDER: return $urandom_range(99) < 60;
      TRAFFIC_BOTH:   return $urandom_range(99) < 23;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rests();
    case (traffic_mode)
      TRAFFIC_RECEIVER: return $urandom_range(99) < 60;
      TRAFFIC_BOTH:     return $urandom_range(99) < 23;
      default:          return 1'b0;
    endcase
  endfunction

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off_taken != hold_off_asks) begin
      hold_off_taken = hold_off_asks;
      hold_left      = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_rests();
    end
  end

  // result check first, then prediction for a request taken on the same edge
  always @(posedge clk) begin
    gen_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_seed_error) error_results++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, out_byte %0d seed_error %0b",
                   $time, out_byte, out_seed_error);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_byte !== exp_r.data) begin
            mismatches++;
            $display("%0t ns: out_byte expected %0d, got %0d",
                     $time, exp_r.data, out_byte);
          end
          if (out_seed_error !== exp_r.seed_err) begin
            mismatches++;
            $display("%0t ns: out_seed_error expected %0b, got %0b",
                     $time, exp_r.seed_err, out_seed_error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_r = next_output(in_restart);
        if (typed_pending) begin
          exp_r         = typed_result;
          typed_pending = 1'b0;
        end
        pending_results.push_back(exp_r);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("bbs_bit_generator_test NOT OK");
    $finish;
  end

  task automatic send_request(input logic restart);
    @(negedge clk);
    while (sender_rests()) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom);
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic release_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      bbs_pkg::REG_MODULUS: gen_modulus = value & MASK63;
      bbs_pkg::REG_SEED:    gen_seed    = value & MASK63;
      bbs_pkg::REG_PACKED:  gen_packed  = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic bus_idle();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void add_write(logic [1:0] idx, logic [63:0] value);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.value   = value;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_request(logic restart);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_REQUEST;
    r.restart = restart;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic restart, logic [7:0] b, logic e);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_REQUEST;
    r.restart    = restart;
    r.typed      = 1'b1;
    r.typed_byte = b;
    r.typed_err  = e;
    directed_rows.push_back(r);
  endfunction

  // new register values for one random phase; slow marks a wide modulus
  task automatic configure_phase(input bit first, output bit slow);
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] p;
    logic [63:0] q;
    int          pick;
    p    = 64'd0;
    q    = 64'd0;
    slow = 1'b0;
    if (first || $urandom_range(99) < 75) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        p = 64'(prime_3mod4[$urandom_range(15)]);
        q = 64'(prime_3mod4[$urandom_range(15)]);
        m = p * q;
      end else if (pick < 70) begin
        m = 64'($urandom_range(65535, 3));
      end else if (pick < 80) begin
        m = {32'd0, $urandom};
        if (m < 3) m = 64'd3;
      end else if (pick < 85) begin
        m = 64'($urandom_range(2));
      end else begin
        slow = 1'b1;
        case ($urandom_range(2))
          0:       m = BIG_BLUM;
          1:       m = MASK63;
          default: m = rand63() | (64'd1 << 62);
        endcase
      end
      // bit 63 is not stored
      write_reg(bbs_pkg::REG_MODULUS,
                m | (($urandom_range(9) == 0) ? (64'd1 << 63) : 64'd0));
    end else begin
      m    = gen_modulus;
      slow = (gen_modulus >> 40) != 0;
    end
    if (first || $urandom_range(99) < 85) begin
      if ($urandom_range(99) < 85 && m >= 2) begin
        for (int t = 0; t < 8; t++) begin
          s = (rand63() % (m - 1)) + 1;
          if (gcd64(m, s) == 1) break;
        end
      end else begin
        case ($urandom_range(3))
          0:       s = 64'd0;
          1:       s = m;
          2:       s = m + 64'($urandom_range(1000, 1));
          default: s = (p != 0) ? p * 64'($urandom_range(32'(q - 1), 1)) : m + 1;
        endcase
      end
      write_reg(bbs_pkg::REG_SEED, s);
    end
    if (first || $urandom_range(1) == 0) begin
      if ($urandom_range(4) == 0)
        write_reg(bbs_pkg::REG_PACKED, {$urandom, 31'($urandom), 1'($urandom)});
      else
        write_reg(bbs_pkg::REG_PACKED, {63'd0, 1'($urandom)});
    end
    bus_idle();
  endtask

  initial begin : stimulus
    stim_row_t row;
    bit        bus_busy;
    bit        slow;
    int        phase;
    int        count;
    logic      restart;

    gen_modulus = 64'd3;
    gen_seed    = 64'd1;
    gen_packed  = 1'b1;
    gen_residue = 64'd0;
    gen_seeded  = 1'b0;
    gen_error   = 1'b0;

    // first request after reset seeds itself; 1 squared stays 1
    add_checked(1'b0, 8'hFF, 1'b0);
    add_checked(1'b0, 8'hFF, 1'b0);
    add_write(bbs_pkg::REG_PACKED, 64'd0);
    add_checked(1'b0, bbs_pkg::ASCII_ZERO + 8'd1, 1'b0);
    add_write(bbs_pkg::REG_SEED, 64'd0);
    add_checked(1'b1, 8'd0, 1'b1);
    add_checked(1'b0, 8'd0, 1'b1);
    add_write(bbs_pkg::REG_SEED, 64'd3);
    add_checked(1'b1, 8'd0, 1'b1);
    add_write(bbs_pkg::REG_SEED, 64'd2);
    add_request(1'b1);
    add_write(bbs_pkg::REG_MODULUS, MASK63);
    add_write(bbs_pkg::REG_SEED, MASK63 - 1);
    add_write(bbs_pkg::REG_PACKED, 64'd1);
    add_request(1'b1);
    add_request(1'b0);
    // shares the factor 7 with 2^63-1
    add_write(bbs_pkg::REG_SEED, 64'd7);
    add_checked(1'b1, 8'd0, 1'b1);
    add_write(bbs_pkg::REG_MODULUS, 64'd21);
    add_write(bbs_pkg::REG_SEED, 64'd2);
    add_request(1'b1);
    add_write(bbs_pkg::REG_SEED, 64'd5);
    add_request(1'b0);
    add_write(bbs_pkg::REG_MODULUS, 64'd19);
    add_request(1'b0);
    add_write(bbs_pkg::REG_MODULUS, 64'd1);
    add_checked(1'b0, 8'd0, 1'b1);
    add_write(bbs_pkg::REG_MODULUS, 64'd0);
    add_checked(1'b1, 8'd0, 1'b1);
    add_write(bbs_pkg::REG_MODULUS, BIG_BLUM);
    add_write(bbs_pkg::REG_SEED, 64'd12345);
    add_request(1'b1);
    add_write(bbs_pkg::REG_PACKED, 64'd0);
    add_request(1'b0);
    add_request(1'b0);
    add_write(bbs_pkg::REG_PACKED, 64'hA5A5_0000_0000_0001);
    add_request(1'b0);
    add_write(bbs_pkg::REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(bbs_pkg::REG_SEED, 64'h8000_0000_0000_0002);
    add_request(1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    bus_busy = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!bus_busy) begin
          release_valid();
          wait_drained();
        end
        write_reg(row.reg_idx, row.value);
        bus_busy = 1'b1;
      end else begin
        if (bus_busy) begin
          bus_idle();
          bus_busy = 1'b0;
        end
        typed_pending = row.typed;
        typed_result  = '{data: row.typed_byte, seed_err: row.typed_err};
        send_request(row.restart);
      end
    end
    release_valid();
    wait_drained();

    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      traffic_mode = traffic_t'(phase % 4);
      configure_phase(phase == 0, slow);
      count = slow ? $urandom_range(4, 2) : $urandom_range(40, 10);
      // receiver holds off while requests keep coming
      if (phase == 6) begin
        hold_off_asks++;
        if (count < 4) count = 4;
      end
      for (int k = 0; k < count; k++) begin
        restart = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0);
        // sender waits for every outstanding result mid-phase
        if (phase == 9 && k == count / 2) begin
          release_valid();
          wait_drained();
        end
        send_request(restart);
      end
      release_valid();
      wait_drained();
      phase++;
    end

    repeat (END_WAIT_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d with restart) over %0d random phases, %0d register writes.",
             requests_sent, restarts_sent, phase, reg_writes);
    $display("Checked %0d results, %0d of them flagging a bad seed.",
             results_seen, error_results);
    if (mismatches == 0) begin
      $display("bbs_bit_generator_test OK");
    end else begin
      $display("bbs_bit_generator_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bbs_pkg.sv
hdl/bbs_modunit.sv
hdl/bbs_bit_generator.sv
hdl/bbs_bit_generator_chk.sv
tb/bbs_bit_generator_test.sv
